>>> design/oaht_pkg.sv
`default_nettype none

package oaht_pkg;

    localparam int LOG_SLOTS = 10;
    localparam int SLOTS     = 1 << LOG_SLOTS;
    localparam int IDX_W     = LOG_SLOTS;
    localparam int CNT_W     = LOG_SLOTS + 1;
    localparam int CAP_W     = 4;
    localparam int WORD_W    = 32;
    localparam int MIN_LOG   = 3;
    localparam int RESET_LOG = 10;

    localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    // Request operations.
    localparam logic [1:0] OP_GET = 2'd0;
    localparam logic [1:0] OP_SET = 2'd1;
    localparam logic [1:0] OP_DEL = 2'd2;

    // Slot states.
    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_LIVE  = 2'd1;
    localparam logic [1:0] ST_TOMB  = 2'd2;

    // Response status codes.
    localparam logic [1:0] RES_DONE      = 2'd0;
    localparam logic [1:0] RES_NOT_FOUND = 2'd1;
    localparam logic [1:0] RES_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]        status;
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] value;
    } slot_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;
        logic load;
        logic issue;
        logic probe;
        logic resolve;
    } oaht_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic probe_done;
        logic out_free;
    } oaht_sts_t;

    function automatic logic [CNT_W-1:0] cap_of(input logic [CAP_W-1:0] lg);
        int unsigned l;
        logic [CNT_W-1:0] cap;
        l = int'(lg);
        if (l < MIN_LOG)
        begin
            l = MIN_LOG;
        end
        if (l > LOG_SLOTS)
        begin
            l = LOG_SLOTS;
        end
        cap = CNT_ONE << l;
        return cap;
    endfunction

    function automatic logic [IDX_W-1:0] mask_of(input logic [CAP_W-1:0] lg);
        logic [CNT_W-1:0] cap;
        cap = cap_of(lg) - CNT_ONE;
        return cap[IDX_W-1:0];
    endfunction

    // Three quarters of the capacity; exact since the capacity is at least 8.
    function automatic logic [CNT_W-1:0] thresh_of(input logic [CAP_W-1:0] lg);
        logic [CNT_W-1:0] cap;
        cap = cap_of(lg);
        return (cap >> 1) + (cap >> 2);
    endfunction

endpackage

`default_nettype wire

>>> design/oaht_if.sv
`default_nettype none

interface oaht_cfg_if
    import oaht_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] capacity_log2;

    modport source (output valid, output capacity_log2, input ready);
    modport sink (input valid, input capacity_log2, output ready);
endinterface

interface oaht_req_if
    import oaht_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] key_hash;
    logic [WORD_W-1:0] write_value;

    modport source (output valid, output op, output key, output key_hash,
                    output write_value, input ready);
    modport sink (input valid, input op, input key, input key_hash,
                  input write_value, output ready);
endinterface

interface oaht_rsp_if
    import oaht_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic              is_new_key;
    logic [WORD_W-1:0] read_value;

    modport source (output valid, output status, output is_new_key,
                    output read_value, input ready);
    modport sink (input valid, input status, input is_new_key,
                  input read_value, output ready);
endinterface

`default_nettype wire

>>> design/open_addressing_hash_table_core.sv
// Channel  Direction  Payload                                  Request accepted
// cfg      in         capacity_log2                            valid && ready
// req      in         op, key, key_hash, write_value           valid && ready
// rsp      out        status, is_new_key, read_value           valid && ready
//
// A request passes from acceptance through the issue, probe and resolve states to
// its response register, probing one slot per cycle (1 to the capacity in use).
// No new request is taken before the last one is resolved, since it is taken in idle.
// After reset and after each capacity write, a clearing pass over all
// 2 ** LOG_SLOTS slots runs; no request is accepted during it.
// A new request is accepted while the previous response waits on rsp.ready.
`default_nettype none

module open_addressing_hash_table_core
    import oaht_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    oaht_cfg_if.sink   cfg,
    oaht_req_if.sink   req,
    oaht_rsp_if.source rsp
);

    oaht_cmd_t cmd;
    oaht_sts_t sts;
    logic      cfg_fire;
    logic      req_ready;

    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid;
    assign req.ready = req_ready;

    oaht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_fire  (cfg_fire),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    oaht_dpath u_dpath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_fire          (cfg_fire),
        .cfg_capacity_log2 (cfg.capacity_log2),
        .cmd               (cmd),
        .sts               (sts),
        .req_op            (req.op),
        .req_key           (req.key),
        .req_key_hash      (req.key_hash),
        .req_write_value   (req.write_value),
        .rsp_ready         (rsp.ready),
        .rsp_valid         (rsp.valid),
        .rsp_status        (rsp.status),
        .rsp_is_new_key    (rsp.is_new_key),
        .rsp_read_value    (rsp.read_value)
    );

endmodule

`default_nettype wire

>>> design/oaht_ctrl.sv
`default_nettype none

module oaht_ctrl
    import oaht_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_fire,
    input  wire logic      req_valid,
    output logic           req_ready,
    input  wire oaht_sts_t sts,
    output oaht_cmd_t      cmd
);

    typedef enum logic [4:0] {
        S_CLEAR   = 5'b00001,
        S_IDLE    = 5'b00010,
        S_ISSUE   = 5'b00100,
        S_PROBE   = 5'b01000,
        S_RESOLVE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                if (sts.probe_done)
                begin
                    state_next = S_RESOLVE;
                end
            end
            S_RESOLVE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
        // A capacity write restarts the clearing pass.
        if (cfg_fire)
        begin
            state_next = S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready      = (state_reg == S_IDLE);
    assign cmd.clear_step = (state_reg == S_CLEAR);
    assign cmd.load       = (state_reg == S_IDLE) && req_valid;
    assign cmd.issue      = (state_reg == S_ISSUE);
    assign cmd.probe      = (state_reg == S_PROBE);
    assign cmd.resolve    = (state_reg == S_RESOLVE) && sts.out_free;

endmodule

`default_nettype wire

>>> design/oaht_dpath.sv
`default_nettype none

module oaht_dpath
    import oaht_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_fire,
    input  wire logic [CAP_W-1:0]  cfg_capacity_log2,
    input  wire oaht_cmd_t         cmd,
    output oaht_sts_t              sts,
    input  wire logic [1:0]        req_op,
    input  wire logic [WORD_W-1:0] req_key,
    input  wire logic [WORD_W-1:0] req_key_hash,
    input  wire logic [WORD_W-1:0] req_write_value,
    input  wire logic              rsp_ready,
    output logic                   rsp_valid,
    output logic [1:0]             rsp_status,
    output logic                   rsp_is_new_key,
    output logic [WORD_W-1:0]      rsp_read_value
);

    slot_t mem [SLOTS];
    slot_t rdata_reg;

    // Configuration and occupancy.
    logic [IDX_W-1:0] mask_reg;
    logic [CNT_W-1:0] thresh_reg;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] clr_idx_reg;

    // Request being served.
    logic [1:0]        op_reg;
    logic [WORD_W-1:0] key_reg;
    logic [WORD_W-1:0] wval_reg;

    // Probe walk.
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [IDX_W-1:0]  chk_idx_reg;
    logic [IDX_W-1:0]  n_reg;
    logic              have_tomb_reg;
    logic [IDX_W-1:0]  tomb_reg;
    logic              found_reg;
    logic              usable_reg;
    logic              where_empty_reg;
    logic [IDX_W-1:0]  where_reg;
    logic [WORD_W-1:0] hit_val_reg;

    // Response register.
    logic              out_valid_reg;
    logic [1:0]        out_status_reg;
    logic              out_new_reg;
    logic [WORD_W-1:0] out_val_reg;

    logic              slot_vacant;
    logic              is_tomb;
    logic              live_hit;
    logic              last;
    logic              done;
    logic              have_now;
    logic [IDX_W-1:0]  tomb_now;
    logic [IDX_W-1:0]  where_next;

    logic              over;
    logic              res_we;
    slot_t             res_word;
    logic [1:0]        res_status;
    logic              res_new;
    logic [WORD_W-1:0] res_val;
    logic              res_inc;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    slot_t             mem_wdata;

    // The slot in rdata_reg is the one at chk_idx_reg.
    always_comb
    begin
        slot_vacant = (rdata_reg.status == ST_EMPTY);
        is_tomb    = (rdata_reg.status == ST_TOMB);
        live_hit   = (rdata_reg.status == ST_LIVE) && (rdata_reg.key == key_reg);
        last       = (n_reg == mask_reg);
        done       = live_hit || slot_vacant || last;
        have_now   = have_tomb_reg || is_tomb;
        tomb_now   = have_tomb_reg ? tomb_reg : chk_idx_reg;
        if (live_hit)
        begin
            where_next = chk_idx_reg;
        end
        else
        begin
            where_next = tomb_now;
        end
    end

    always_comb
    begin
        over       = (count_reg >= thresh_reg);
        res_we     = 1'b0;
        res_word   = '{status: ST_LIVE, key: key_reg, value: wval_reg};
        res_status = RES_NOT_FOUND;
        res_new    = 1'b0;
        res_val    = '0;
        res_inc    = 1'b0;
        case (op_reg)
            OP_GET:
            begin
                if (found_reg)
                begin
                    res_status = RES_DONE;
                    res_val    = hit_val_reg;
                end
            end
            OP_SET:
            begin
                if (found_reg)
                begin
                    res_we     = 1'b1;
                    res_status = RES_DONE;
                end
                else if (over || !usable_reg)
                begin
                    res_status = RES_FULL;
                end
                else
                begin
                    res_we     = 1'b1;
                    res_status = RES_DONE;
                    res_new    = 1'b1;
                    res_inc    = where_empty_reg;
                end
            end
            OP_DEL:
            begin
                if (found_reg)
                begin
                    res_we     = 1'b1;
                    res_word   = '{status: ST_TOMB, key: key_reg, value: hit_val_reg};
                    res_status = RES_DONE;
                end
            end
            default:
            begin
                res_status = RES_NOT_FOUND;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.clear_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = cmd.resolve && res_we;
            mem_waddr = where_reg;
            mem_wdata = res_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[rd_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= mask_of(CAP_W'(RESET_LOG));
            thresh_reg    <= thresh_of(CAP_W'(RESET_LOG));
            count_reg     <= '0;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
            begin
                mask_reg    <= mask_of(cfg_capacity_log2);
                thresh_reg  <= thresh_of(cfg_capacity_log2);
                count_reg   <= '0;
                clr_idx_reg <= '0;
            end
            else
            begin
                if (cmd.clear_step)
                begin
                    clr_idx_reg <= clr_idx_reg + IDX_ONE;
                end
                if (cmd.resolve && res_inc)
                begin
                    count_reg <= count_reg + CNT_ONE;
                end
            end
            if (cmd.resolve)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= req_op;
            key_reg    <= req_key;
            wval_reg   <= req_write_value;
            rd_idx_reg <= req_key_hash[IDX_W-1:0] & mask_reg;
        end
        else if (cmd.issue || (cmd.probe && !done))
        begin
            rd_idx_reg  <= (rd_idx_reg + IDX_ONE) & mask_reg;
            chk_idx_reg <= rd_idx_reg;
        end
        if (cmd.issue)
        begin
            n_reg         <= '0;
            have_tomb_reg <= 1'b0;
            tomb_reg      <= '0;
        end
        else if (cmd.probe)
        begin
            if (done)
            begin
                found_reg       <= live_hit;
                usable_reg      <= live_hit || slot_vacant || have_now;
                where_empty_reg <= slot_vacant && !have_tomb_reg;
                where_reg       <= where_next;
                hit_val_reg     <= rdata_reg.value;
            end
            else
            begin
                n_reg         <= n_reg + IDX_ONE;
                have_tomb_reg <= have_now;
                tomb_reg      <= tomb_now;
            end
        end
        if (cmd.resolve)
        begin
            out_status_reg <= res_status;
            out_new_reg    <= res_new;
            out_val_reg    <= res_val;
        end
    end

    assign sts.clear_last = (clr_idx_reg == '1);
    assign sts.probe_done = done;
    assign sts.out_free   = !out_valid_reg || rsp_ready;

    assign rsp_valid      = out_valid_reg;
    assign rsp_status     = out_status_reg;
    assign rsp_is_new_key = out_new_reg;
    assign rsp_read_value = out_val_reg;

endmodule

`default_nettype wire

>>> design/oaht_checker.sv
`default_nettype none

module oaht_checker
    import oaht_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              cfg_valid,
    input wire logic              cfg_ready,
    input wire logic              req_valid,
    input wire logic              req_ready,
    input wire logic              rsp_valid,
    input wire logic              rsp_ready,
    input wire logic [1:0]        status,
    input wire logic              is_new_key,
    input wire logic [WORD_W-1:0] read_value
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
            && $stable(is_new_key) && $stable(read_value))
        else $error("response changed while stalled");

    // One request at a time: acceptance closes the request channel.
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in flight");

    // A capacity write starts the clearing pass.
    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !req_ready)
        else $error("request channel open after capacity write");

    a_new_key: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && is_new_key |-> status == RES_DONE && read_value == '0)
        else $error("new key reported with wrong status or value");

    a_value_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && read_value != '0 |-> status == RES_DONE && !is_new_key)
        else $error("value returned without a found key");

endmodule

bind open_addressing_hash_table_core oaht_checker u_oaht_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg.valid),
    .cfg_ready  (cfg.ready),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .status     (rsp.status),
    .is_new_key (rsp.is_new_key),
    .read_value (rsp.read_value)
);

`default_nettype wire

>>> test/oaht_table_checker.sv
`default_nettype none

module oaht_table_checker
    import oaht_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    oaht_cfg_if       cfg,
    oaht_req_if       req,
    oaht_rsp_if       rsp,
    output int        outstanding,
    output int        mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]        status;
        logic              is_new_key;
        logic [WORD_W-1:0] read_value;
    } table_answer_t;

    table_answer_t     pending_answers[$];
    logic [1:0]        slot_state [SLOTS];
    logic [WORD_W-1:0] stored_key [SLOTS];
    logic [WORD_W-1:0] stored_value [SLOTS];
    int unsigned       fill_count;
    logic [CAP_W-1:0]  cap_log;
    int                errors;

    function automatic int unsigned slots_in_use();
        int unsigned lg;
        lg = int'(cap_log);
        if (lg < MIN_LOG)
        begin
            lg = MIN_LOG;
        end
        if (lg > LOG_SLOTS)
        begin
            lg = LOG_SLOTS;
        end
        return 1 << lg;
    endfunction

    function automatic void wipe_table();
        foreach (slot_state[i])
        begin
            slot_state[i] = ST_EMPTY;
        end
        fill_count = 0;
    endfunction

    // Linear probe. Returns 1 on a live match; otherwise where is the slot a
    // set would take (first tombstone preferred) and usable tells if one exists.
    function automatic bit probe_slots(input logic [WORD_W-1:0] key,
                                       input logic [WORD_W-1:0] hash,
                                       output int unsigned where,
                                       output bit usable);
        int unsigned cap;
        int unsigned mask;
        int unsigned idx;
        int unsigned tomb;
        bit          have_tomb;
        cap = slots_in_use();
        mask = cap - 1;
        idx = hash & mask;
        tomb = 0;
        have_tomb = 1'b0;
        where = 0;
        usable = 1'b0;
        for (int unsigned n = 0; n < cap; n++)
        begin
            if (slot_state[idx] == ST_EMPTY)
            begin
                where = have_tomb ? tomb : idx;
                usable = 1'b1;
                return 1'b0;
            end
            if (slot_state[idx] == ST_LIVE)
            begin
                if (stored_key[idx] == key)
                begin
                    where = idx;
                    usable = 1'b1;
                    return 1'b1;
                end
            end
            else if (!have_tomb)
            begin
                have_tomb = 1'b1;
                tomb = idx;
            end
            idx = (idx + 1) & mask;
        end
        where = tomb;
        usable = have_tomb;
        return 1'b0;
    endfunction

    function automatic table_answer_t predict_table_op(input logic [1:0] op,
                                                       input logic [WORD_W-1:0] key,
                                                       input logic [WORD_W-1:0] hash,
                                                       input logic [WORD_W-1:0] wval);
        table_answer_t ans;
        int unsigned   where;
        int unsigned   cap;
        bit            usable;
        ans.status = RES_NOT_FOUND;
        ans.is_new_key = 1'b0;
        ans.read_value = '0;
        where = 0;
        usable = 1'b0;
        cap = slots_in_use();
        case (op)
            OP_GET:
            begin
                if (fill_count != 0 && probe_slots(key, hash, where, usable))
                begin
                    ans.status = RES_DONE;
                    ans.read_value = stored_value[where];
                end
            end
            OP_SET:
            begin
                if (probe_slots(key, hash, where, usable))
                begin
                    stored_value[where] = wval;
                    ans.status = RES_DONE;
                end
                else if (fill_count + 1 > (cap * 3) / 4 || !usable)
                begin
                    // Absent key over the load limit is refused, tombstone or not.
                    ans.status = RES_FULL;
                end
                else
                begin
                    if (slot_state[where] == ST_EMPTY)
                    begin
                        fill_count++;
                    end
                    slot_state[where] = ST_LIVE;
                    stored_key[where] = key;
                    stored_value[where] = wval;
                    ans.status = RES_DONE;
                    ans.is_new_key = 1'b1;
                end
            end
            OP_DEL:
            begin
                if (fill_count != 0 && probe_slots(key, hash, where, usable))
                begin
                    slot_state[where] = ST_TOMB;
                    ans.status = RES_DONE;
                end
            end
            default:
            begin
            end
        endcase
        return ans;
    endfunction

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        table_answer_t want;
        if (!rst_n)
        begin
            cap_log = CAP_W'(RESET_LOG);
            wipe_table();
            pending_answers.delete();
            errors = 0;
            outstanding <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_answers.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected response, expected none, got %h/%h/%h",
                             $time, rsp.status, rsp.is_new_key, rsp.read_value);
                end
                else
                begin
                    want = pending_answers.pop_front();
                    check_field("status", WORD_W'(want.status), WORD_W'(rsp.status));
                    check_field("is_new_key", WORD_W'(want.is_new_key),
                                WORD_W'(rsp.is_new_key));
                    check_field("read_value", want.read_value, rsp.read_value);
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                cap_log = cfg.capacity_log2;
                wipe_table();
            end
            if (req.valid && req.ready)
            begin
                pending_answers.push_back(predict_table_op(req.op, req.key, req.key_hash,
                                                           req.write_value));
            end
            outstanding <= pending_answers.size();
            mismatches <= errors;
        end
    end

endmodule

`default_nettype wire

>>> test/open_addressing_hash_table_core_tb.sv
`default_nettype none

module open_addressing_hash_table_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import oaht_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int LONG_HOLD = 300;
    localparam int DRAIN = 16;
    localparam int PHASES = 10;
    localparam int PHASE_ITEMS = 43;
    localparam int POOL_MAX = 24;
    // Capacity settings per random phase, phase 0 in the low nibble.
    localparam logic [PHASES*CAP_W-1:0] CAP_PLAN =
        {4'd7, 4'd6, 4'd2, 4'd5, 4'd11, 4'd4, 4'd10, 4'd1, 4'd3, 4'd15};

    logic clk;
    logic rst_n;
    int   outstanding;
    int   mismatches;
    int   requests_sent;
    int   cap_writes;
    int   hold_token;
    bit   no_idle;
    int   pool_n;
    logic [WORD_W-1:0] pool_key [POOL_MAX];
    logic [WORD_W-1:0] pool_hash [POOL_MAX];

    oaht_cfg_if cfg_ch ();
    oaht_req_if req_ch ();
    oaht_rsp_if rsp_ch ();

    open_addressing_hash_table_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    oaht_table_checker table_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_ch),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    task automatic offer(input logic [1:0] op, input logic [WORD_W-1:0] key,
                         input logic [WORD_W-1:0] hash, input logic [WORD_W-1:0] wval);
        req_ch.valid <= 1'b1;
        req_ch.op <= op;
        req_ch.key <= key;
        req_ch.key_hash <= hash;
        req_ch.write_value <= wval;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        requests_sent++;
    endtask

    task automatic maybe_pause();
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (outstanding != 0);
        repeat (DRAIN) @(posedge clk);
    endtask

    // The new setting also sizes the key pool so that small tables reach full.
    task automatic write_capacity(input logic [CAP_W-1:0] lg);
        int unsigned eff;
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.capacity_log2 <= lg;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        cap_writes++;
        eff = (int'(lg) < MIN_LOG) ? MIN_LOG :
              ((int'(lg) > LOG_SLOTS) ? LOG_SLOTS : int'(lg));
        pool_n = ((1 << eff) * 3) / 4 + 3;
        if (pool_n > POOL_MAX)
        begin
            pool_n = POOL_MAX;
        end
        for (int k = 0; k < pool_n; k++)
        begin
            pool_key[k] = $urandom;
            // Half the keys share a few start slots to build clusters.
            if ($urandom_range(0, 1) == 0)
            begin
                pool_hash[k] = pool_key[k];
            end
            else
            begin
                pool_hash[k] = (WORD_W'($urandom) << LOG_SLOTS)
                               | WORD_W'($urandom_range(0, 3));
            end
        end
    endtask

    task automatic random_request();
        int k;
        int r;
        logic [1:0] op;
        if ($urandom_range(0, 99) < 15)
        begin
            offer(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
        end
        else
        begin
            k = $urandom_range(0, pool_n - 1);
            r = $urandom_range(0, 99);
            op = (r < 45) ? OP_SET : (r < 75) ? OP_GET : (r < 95) ? OP_DEL : OP_NONE;
            offer(op, pool_key[k], pool_hash[k], $urandom);
        end
    endtask

    // Response side: random ready bursts, one long hold on request.
    initial
    begin
        int hold_seen;
        hold_seen = 0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (no_idle)
            begin
                rsp_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    initial
    begin
        #3000000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        requests_sent = 0;
        cap_writes = 0;
        pool_n = 1;
        rst_n <= 1'b0;
        hold_token <= 0;
        no_idle <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.capacity_log2 <= '0;
        req_ch.valid <= 1'b0;
        req_ch.op <= OP_GET;
        req_ch.key <= '0;
        req_ch.key_hash <= '0;
        req_ch.write_value <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full-size table after reset: empty-table lookups, word extremes,
        // update in place, and a tombstone passed over and then reused.
        offer(OP_GET, 32'h1234_5678, 32'h1234_5678, 32'h0);
        offer(OP_DEL, 32'h1234_5678, 32'h1234_5678, 32'h0);
        offer(OP_NONE, 32'h0, 32'h0, 32'hFFFF_FFFF);
        offer(OP_SET, 32'h0, 32'h0, 32'h0);
        offer(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer(OP_GET, 32'h0, 32'h0, 32'h0);
        offer(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        offer(OP_SET, 32'h0, 32'h0, 32'hA5A5_A5A5);
        offer(OP_GET, 32'h0, 32'h0, 32'h0);
        offer(OP_SET, 32'h400, 32'h400, 32'h1);
        offer(OP_DEL, 32'h0, 32'h0, 32'h0);
        offer(OP_GET, 32'h400, 32'h400, 32'h0);
        offer(OP_DEL, 32'h0, 32'h0, 32'h0);
        offer(OP_SET, 32'h800, 32'h800, 32'h2);
        offer(OP_GET, 32'h800, 32'h800, 32'h0);

        // Out-of-range low setting: eight slots, load limit of six.
        write_capacity(4'd0);
        for (int k = 1; k <= 6; k++)
        begin
            offer(OP_SET, k, k, 32'h100 + k);
        end
        offer(OP_SET, 32'h7, 32'h7, 32'h7);
        offer(OP_SET, 32'h3, 32'h3, 32'h5A5A_5A5A);
        offer(OP_DEL, 32'h2, 32'h2, 32'h0);
        offer(OP_SET, 32'h9, 32'h1, 32'h9);
        offer(OP_GET, 32'h2, 32'h2, 32'h0);
        offer(OP_GET, 32'h3, 32'h3, 32'h0);
        offer(OP_NONE, 32'h3, 32'h3, 32'h0);

        for (int p = 0; p < PHASES; p++)
        begin
            write_capacity(CAP_PLAN[p*CAP_W +: CAP_W]);
            if (p == PHASES - 1)
            begin
                no_idle <= 1'b1;
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 3 && i == 5)
                begin
                    hold_token <= hold_token + 1;
                end
                if (p == 5 && i == PHASE_ITEMS / 2)
                begin
                    wait_idle();
                end
                maybe_pause();
                random_request();
            end
        end
        wait_idle();

        $display("Summary: %0d requests across %0d capacity writes, %s",
                 requests_sent, cap_writes, "out-of-range settings included.");
        $display("Covered full-table refusals, tombstone reuse, collisions and a long stall.");
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
